@@ hw/rtl/bresenham_line_stepper_macros.svh @@
// ---------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Shorthand for the concurrent checks of the line stepper.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/blsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper package
// Item kinds and the control structs passed between the stepper's parts.
// ---------------------------------------------------------------------------
package blsp_pkg;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  dir_x_neg;
        logic  dir_y_neg;
        logic  major_is_x;
    } cmd_ctrl_t;

    typedef struct packed {
        logic active;
        logic emit;
        logic at_end;
        logic cmd_pop;
    } back_status_t;

endpackage

@@ hw/rtl/bresenham_line_stepper.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper
// All-octant integer line stepper: a load item sets up a line, each step
// item on an active line returns the next pixel with its major-axis progress.
//
// Channel   Direction  Handshake     Payload
// input     in         push / full   kind, start_x, start_y, end_x, end_y
// result    out        pop / empty   pixel_x, pixel_y, major_done,
//                                    major_length, last
//
// An item is classified and set up in the cycle it is pushed and waits in a
// two-entry command queue. The back end takes one item per cycle from it
// and stalls only on a step for an active line while the result queue is
// full; the front stalls only on a full command queue. A step item goes
// from the command queue to the two-entry result queue when it is emitted.
// Reset empties both queues and clears the line state.
// ---------------------------------------------------------------------------
`include "bresenham_line_stepper_macros.svh"

module bresenham_line_stepper
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          kind,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic [COORD_BITS-1:0]         major_done,
    output logic [COORD_BITS-1:0]         major_length,
    output logic                          last
);

    localparam int C         = COORD_BITS;
    localparam int CTRL_BITS = $bits(cmd_ctrl_t);
    localparam int CMD_BITS  = CTRL_BITS + 6 * C;
    localparam int RES_BITS  = 4 * C + 1;

    cmd_ctrl_t            front_ctrl;
    logic [C-1:0]         front_dx;
    logic [C-1:0]         front_dy;
    logic [CMD_BITS-1:0]  cmd_wdata;
    logic [CMD_BITS-1:0]  cmd_rdata;
    logic                 cmd_empty;
    logic                 cmd_pop;
    cmd_ctrl_t            cmd_ctrl;
    logic [C-1:0]         cmd_origin_x;
    logic [C-1:0]         cmd_origin_y;
    logic [C-1:0]         cmd_target_x;
    logic [C-1:0]         cmd_target_y;
    logic [C-1:0]         cmd_step_dx;
    logic [C-1:0]         cmd_step_dy;
    logic                 res_full;
    logic                 res_push;
    logic [RES_BITS-1:0]  res_wdata;
    logic [RES_BITS-1:0]  res_rdata;
    back_status_t         status;

    blsp_front #(.COORD_BITS(C)) u_front (
        .kind    (kind),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .ctrl    (front_ctrl),
        .step_dx (front_dx),
        .step_dy (front_dy)
    );

    assign cmd_wdata = {front_ctrl, start_x, start_y, end_x, end_y, front_dx, front_dy};

    blsp_queue #(.WIDTH(CMD_BITS), .DEPTH(2)) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_wdata),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign {cmd_ctrl, cmd_origin_x, cmd_origin_y, cmd_target_x, cmd_target_y,
            cmd_step_dx, cmd_step_dy} = cmd_rdata;

    blsp_back #(.COORD_BITS(C)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_ctrl     (cmd_ctrl),
        .cmd_origin_x (cmd_origin_x),
        .cmd_origin_y (cmd_origin_y),
        .cmd_target_x (cmd_target_x),
        .cmd_target_y (cmd_target_y),
        .cmd_step_dx  (cmd_step_dx),
        .cmd_step_dy  (cmd_step_dy),
        .cmd_pop      (cmd_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_data     (res_wdata),
        .status       (status)
    );

    blsp_queue #(.WIDTH(RES_BITS), .DEPTH(2)) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign {pixel_x, pixel_y, major_done, major_length, last} = res_rdata;

    `BLSP_ASSERT_NOW(a_emit_has_room, clk, rst_n, status.emit, !res_full && status.active, "Pixel emitted without room or line")
    `BLSP_ASSERT_NOW(a_pop_has_item, clk, rst_n, status.cmd_pop, !cmd_empty, "Command taken from an empty queue")
    `BLSP_ASSERT_NEXT(a_end_stops_line, clk, rst_n, status.emit && status.at_end && !(cmd_ctrl.kind == KIND_LOAD), !status.active, "Line still active after its endpoint")

endmodule

@@ hw/rtl/blsp_front.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper front end
// Classifies an item and works out the line setup for a load.
// ---------------------------------------------------------------------------
module blsp_front
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                   kind,
    input  logic [COORD_BITS-1:0]  start_x,
    input  logic [COORD_BITS-1:0]  start_y,
    input  logic [COORD_BITS-1:0]  end_x,
    input  logic [COORD_BITS-1:0]  end_y,
    output cmd_ctrl_t              ctrl,
    output logic [COORD_BITS-1:0]  step_dx,
    output logic [COORD_BITS-1:0]  step_dy
);

    logic [COORD_BITS:0] diff_x;
    logic [COORD_BITS:0] diff_y;
    logic [COORD_BITS:0] abs_x;
    logic [COORD_BITS:0] abs_y;

    always_comb
    begin
        diff_x = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        diff_y = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
        abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
        step_dx = abs_x[COORD_BITS-1:0];
        step_dy = abs_y[COORD_BITS-1:0];
        ctrl.kind       = kind_t'(kind);
        ctrl.dir_x_neg  = diff_x[COORD_BITS] || (diff_x == '0);
        ctrl.dir_y_neg  = diff_y[COORD_BITS] || (diff_y == '0);
        ctrl.major_is_x = (step_dx > step_dy);
    end

endmodule

@@ hw/rtl/blsp_queue.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper queue
// Small first-in first-out store with full and empty flags.
// ---------------------------------------------------------------------------
module blsp_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full   = (count_reg == CNT_BITS'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/blsp_back.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper back end
// Holds the line state, emits one pixel per step item on an active line, advances the error.
// ---------------------------------------------------------------------------
module blsp_back
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_empty,
    input  cmd_ctrl_t                 cmd_ctrl,
    input  logic [COORD_BITS-1:0]     cmd_origin_x,
    input  logic [COORD_BITS-1:0]     cmd_origin_y,
    input  logic [COORD_BITS-1:0]     cmd_target_x,
    input  logic [COORD_BITS-1:0]     cmd_target_y,
    input  logic [COORD_BITS-1:0]     cmd_step_dx,
    input  logic [COORD_BITS-1:0]     cmd_step_dy,
    output logic                      cmd_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output logic [4*COORD_BITS:0]     res_data,
    output back_status_t              status
);

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic [C-1:0]        cur_x_reg,    cur_x_next;
    logic [C-1:0]        cur_y_reg,    cur_y_next;
    logic [C-1:0]        origin_x_reg, origin_x_next;
    logic [C-1:0]        origin_y_reg, origin_y_next;
    logic [C-1:0]        target_x_reg, target_x_next;
    logic [C-1:0]        target_y_reg, target_y_next;
    logic [C-1:0]        step_dx_reg,  step_dx_next;
    logic signed [C:0]   step_dy_neg_reg, step_dy_neg_next;
    logic signed [E-1:0] error_reg,    error_next;
    logic                dir_x_neg_reg, dir_x_neg_next;
    logic                dir_y_neg_reg, dir_y_neg_next;
    logic                major_is_x_reg, major_is_x_next;
    logic                active_reg,   active_next;

    logic                is_load;
    logic                emit;
    logic                at_end;
    logic signed [E:0]   e2;
    logic signed [E:0]   dyn_wide;
    logic signed [E:0]   dx_wide;
    logic                move_x;
    logic                move_y;
    logic [C-1:0]        sel_cur;
    logic [C-1:0]        sel_org;
    logic [C:0]          done_diff;
    logic [C:0]          done_abs;
    logic [C:0]          len_wide;
    logic [C-1:0]        done;
    logic [C-1:0]        len;

    assign is_load = !cmd_empty && (cmd_ctrl.kind == KIND_LOAD);
    assign emit    = !cmd_empty && (cmd_ctrl.kind == KIND_STEP) && active_reg && !res_full;
    assign cmd_pop = !cmd_empty && ((cmd_ctrl.kind == KIND_LOAD) || !active_reg || !res_full);
    assign at_end  = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    always_comb
    begin
        e2       = {error_reg[E-1], error_reg} <<< 1;
        dyn_wide = {{(E-C){step_dy_neg_reg[C]}}, step_dy_neg_reg};
        dx_wide  = {{(E+1-C){1'b0}}, step_dx_reg};
        move_x   = (e2 >= dyn_wide);
        move_y   = (e2 <= dx_wide);
        sel_cur   = major_is_x_reg ? cur_x_reg : cur_y_reg;
        sel_org   = major_is_x_reg ? origin_x_reg : origin_y_reg;
        done_diff = {sel_cur[C-1], sel_cur} - {sel_org[C-1], sel_org};
        done_abs  = done_diff[C] ? (~done_diff + 1'b1) : done_diff;
        done      = done_abs[C-1:0];
        len_wide  = ~step_dy_neg_reg + 1'b1;
        len       = major_is_x_reg ? step_dx_reg : len_wide[C-1:0];
    end

    assign res_push = emit;
    assign res_data = {cur_x_reg, cur_y_reg, done, len, at_end};
    assign status   = '{active: active_reg, emit: emit, at_end: at_end, cmd_pop: cmd_pop};

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        step_dx_next     = step_dx_reg;
        step_dy_neg_next = step_dy_neg_reg;
        error_next       = error_reg;
        dir_x_neg_next   = dir_x_neg_reg;
        dir_y_neg_next   = dir_y_neg_reg;
        major_is_x_next  = major_is_x_reg;
        active_next      = active_reg;
        if (is_load)
        begin
            origin_x_next    = cmd_origin_x;
            origin_y_next    = cmd_origin_y;
            target_x_next    = cmd_target_x;
            target_y_next    = cmd_target_y;
            cur_x_next       = cmd_origin_x;
            cur_y_next       = cmd_origin_y;
            step_dx_next     = cmd_step_dx;
            step_dy_neg_next = ~{1'b0, cmd_step_dy} + 1'b1;
            error_next       = {{(E-C){1'b0}}, cmd_step_dx} - {{(E-C){1'b0}}, cmd_step_dy};
            dir_x_neg_next   = cmd_ctrl.dir_x_neg;
            dir_y_neg_next   = cmd_ctrl.dir_y_neg;
            major_is_x_next  = cmd_ctrl.major_is_x;
            active_next      = 1'b1;
        end
        else if (emit)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                error_next = error_reg
                           + (move_x ? dyn_wide[E-1:0] : '0)
                           + (move_y ? dx_wide[E-1:0] : '0);
                if (move_x)
                begin
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            step_dx_reg     <= '0;
            step_dy_neg_reg <= '0;
            error_reg       <= '0;
            dir_x_neg_reg   <= 1'b0;
            dir_y_neg_reg   <= 1'b0;
            major_is_x_reg  <= 1'b0;
            active_reg      <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            step_dx_reg     <= step_dx_next;
            step_dy_neg_reg <= step_dy_neg_next;
            error_reg       <= error_next;
            dir_x_neg_reg   <= dir_x_neg_next;
            dir_y_neg_reg   <= dir_y_neg_next;
            major_is_x_reg  <= major_is_x_next;
            active_reg      <= active_next;
        end
    end

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// Bresenham line stepper testbench
// Loads lines and requests their pixels through the queue-style input.
// Every accepted item is run through a behavioural line tracer. Each pixel
// that the block returns is compared field by field with the oldest
// predicted pixel. The run covers directed corner cases and random lines
// with short and long gaps on both sides. It also covers a long result
// stall that backs up the input, and a finishing stretch with no gaps.
// ---------------------------------------------------------------------------
module testbench;
    import blsp_pkg::*;

    localparam int COORD_W = 12;
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int LONG_HOLD_CYCLES = 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        span_t;
    typedef logic signed [COORD_W:0]   rise_t;
    typedef logic signed [COORD_W+2:0] err_t;

    typedef struct {
        coord_t x;
        coord_t y;
        span_t  done;
        span_t  length;
        logic   last;
    } pixel_t;

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    kind_t  kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   empty;
    logic   pop;
    coord_t pixel_x;
    coord_t pixel_y;
    span_t  major_done;
    span_t  major_length;
    logic   last;

    coord_t org_x, org_y, tgt_x, tgt_y, pos_x, pos_y;
    span_t  run_x;
    rise_t  rise_neg;
    err_t   err_acc;
    logic   x_back, y_back, major_x, line_on;

    pixel_t pending_pixels[$];
    int     failures = 0;
    int     useful_items = 0;
    int     lines_loaded = 0;
    int     pixels_checked = 0;
    int     ignored_steps = 0;
    int     idle_rate = 4;
    bit     hold_request = 1'b0;

    bresenham_line_stepper #(
        .COORD_BITS(COORD_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .empty       (empty),
        .pop         (pop),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .major_done  (major_done),
        .major_length(major_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int span(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void trace_line_item(kind_t k, coord_t sx, coord_t sy, coord_t ex,
                                            coord_t ey);
        pixel_t px;
        int     e2;
        int     err;
        logic   at_end;
        if (k == KIND_LOAD)
        begin
            org_x    = sx;
            org_y    = sy;
            tgt_x    = ex;
            tgt_y    = ey;
            pos_x    = sx;
            pos_y    = sy;
            run_x    = span_t'(span(ex, sx));
            rise_neg = rise_t'(-span(ey, sy));
            x_back   = !(sx < ex);
            y_back   = !(sy < ey);
            err_acc  = err_t'(int'(run_x) + int'(rise_neg));
            major_x  = int'(run_x) > -int'(rise_neg);
            line_on  = 1'b1;
            useful_items++;
            lines_loaded++;
        end
        else if (!line_on)
        begin
            ignored_steps++;
        end
        else
        begin
            at_end    = (pos_x == tgt_x) && (pos_y == tgt_y);
            px.x      = pos_x;
            px.y      = pos_y;
            px.done   = span_t'(major_x ? span(pos_x, org_x) : span(pos_y, org_y));
            px.length = major_x ? run_x : span_t'(-int'(rise_neg));
            px.last   = at_end;
            pending_pixels.push_back(px);
            useful_items++;
            if (at_end)
            begin
                line_on = 1'b0;
            end
            else
            begin
                err = int'(err_acc);
                e2  = 2 * err;
                if (e2 >= int'(rise_neg))
                begin
                    err   = err + int'(rise_neg);
                    pos_x = coord_t'(int'(pos_x) + (x_back ? -1 : 1));
                end
                if (e2 <= int'(run_x))
                begin
                    err   = err + int'(run_x);
                    pos_y = coord_t'(int'(pos_y) + (y_back ? -1 : 1));
                end
                err_acc = err_t'(err);
            end
        end
    endfunction

    function automatic void check_field(string name, int want, span_t got, bit is_signed);
        int got_i;
        got_i = is_signed ? int'(coord_t'(got)) : int'(got);
        if ($isunknown(got) || got_i != want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got_i);
            failures++;
        end
    endfunction

    function automatic void check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("pixel (%0d, %0d) returned with none predicted", pixel_x, pixel_y);
            failures++;
        end
        else
        begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", int'(want.x), pixel_x, 1'b1);
            check_field("pixel_y", int'(want.y), pixel_y, 1'b1);
            check_field("major_done", int'(want.done), major_done, 1'b0);
            check_field("major_length", int'(want.length), major_length, 1'b0);
            check_field("last", int'(want.last), span_t'(last), 1'b0);
            pixels_checked++;
        end
    endfunction

    function automatic bit take_a_break();
        return (idle_rate != 0) && ($urandom_range(1, idle_rate) == 1);
    endfunction

    // Result side: random pop gaps, plus one long hold when a test asks for it.
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_pixel();
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (take_a_break())
            begin
                stall_left = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_item(kind_t k, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        push    <= 1'b1;
        kind    <= k;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        @(posedge clk);
        while (full)
            @(posedge clk);
        trace_line_item(k, sx, sy, ex, ey);
        if (take_a_break())
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic send_load(int sx, int sy, int ex, int ey);
        send_item(KIND_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    endtask

    task automatic send_step();
        send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    function automatic int end_near(int s, int reach);
        int d;
        int e;
        d = int'($urandom_range(0, 2 * reach)) - reach;
        e = s + d;
        if (e > COORD_MAX || e < COORD_MIN)
            e = s - d;
        return e;
    endfunction

    function automatic int random_coord();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        return int'(coord_t'($urandom_range(0, (1 << COORD_W) - 1)));
    endfunction

    // Mostly whole lines; some are cut short by the next load and some are
    // followed by steps that find no line.
    task automatic trace_random_line();
        int sx, sy, ex, ey, reach, pixels, steps;
        reach = ($urandom_range(0, 11) == 0) ? 60 : 12;
        sx = random_coord();
        sy = random_coord();
        ex = end_near(sx, reach);
        ey = end_near(sy, reach);
        if ($urandom_range(0, 15) == 0)
        begin
            ex = sx;
            ey = sy;
        end
        pixels = ((span(ex, sx) > span(ey, sy)) ? span(ex, sx) : span(ey, sy)) + 1;
        case ($urandom_range(0, 9))
            0:       steps = $urandom_range(0, pixels - 1);
            1:       steps = pixels + $urandom_range(1, 3);
            default: steps = pixels;
        endcase
        send_load(sx, sy, ex, ey);
        repeat (steps) send_step();
    endtask

    task automatic run_lines(int budget, bit vary_idling);
        int stop_at;
        stop_at = useful_items + budget;
        while (useful_items < stop_at)
        begin
            if (vary_idling)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_rate = 0;
                    1:       idle_rate = 2;
                    default: idle_rate = 8;
                endcase
            end
            trace_random_line();
        end
    endtask

    task automatic test_step_without_line();
        repeat (2) send_step();
    endtask

    task automatic test_degenerate_line();
        send_load(5, -7, 5, -7);
        repeat (2) send_step();
    endtask

    task automatic test_field_extremes();
        send_load(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        repeat (2) send_step();
        send_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        repeat (2) send_step();
    endtask

    task automatic test_reload_mid_line();
        send_load(0, 0, 3, 1);
        repeat (2) send_step();
        send_load(-4, 2, 1, -5);
        repeat (9) send_step();
    endtask

    task automatic test_major_axis_tie();
        send_load(0, 0, -3, 3);
        repeat (4) send_step();
    endtask

    task automatic test_random_lines();
        run_lines(480, 1'b1);
    endtask

    task automatic test_result_backpressure();
        idle_rate    = 0;
        hold_request = 1'b1;
        send_load(10, 10, -3, 2);
        repeat (14) send_step();
    endtask

    task automatic test_drain_pause();
        idle_rate = 4;
        send_load(-100, 50, -92, 60);
        repeat (5) send_step();
        push <= 1'b0;
        wait (pending_pixels.size() == 0);
        @(posedge clk);
        repeat (6) send_step();
    endtask

    task automatic test_back_to_back();
        idle_rate = 0;
        run_lines(110, 1'b0);
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        push    <= 1'b0;
        kind    <= KIND_LOAD;
        start_x <= '0;
        start_y <= '0;
        end_x   <= '0;
        end_y   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_step_without_line();
        test_degenerate_line();
        test_field_extremes();
        test_reload_mid_line();
        test_major_axis_tie();
        test_random_lines();
        test_result_backpressure();
        test_drain_pause();
        test_back_to_back();

        push <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (16) @(posedge clk);

        $display("testbench: %0d lines loaded, %0d pixels checked, %0d idle steps ignored",
                 lines_loaded, pixels_checked, ignored_steps);
        $display("testbench: %0d mismatches over %0d items that did work",
                 failures, useful_items);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/blsp_pkg.sv
hw/rtl/blsp_front.sv
hw/rtl/blsp_queue.sv
hw/rtl/blsp_back.sv
hw/rtl/bresenham_line_stepper.sv
sim/testbench.sv
